// ----- design/nnts_pkg.sv -----
// ----------------------------------------------------------------------------
// nnts_pkg
// Shared constants and types of the nearest-neighbor tour search block.
// ----------------------------------------------------------------------------
`default_nettype none

package nnts_pkg;

  localparam int unsigned MAX_NODES_DEF   = 16;
  localparam int unsigned WEIGHT_BITS_DEF = 16;

  // Fixed port widths
  localparam int unsigned NODE_W   = 4;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned LEN_W    = 20;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [LEN_W-1:0] LEN_MAX        = '1;
  localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(16);

  // Register word index (paddr[2])
  localparam logic REG_NODE_COUNT = 1'b0;

  // Controller to datapath commands
  typedef struct packed {
    logic write_in;
    logic begin_search;
    logic init_tour;
    logic scan_rd;
    logic pick;
    logic close_rd;
    logic close;
    logic emit_rd;
    logic emit_first;
    logic load_out;
    logic emit_last;
  } cmd_t;

endpackage

`default_nettype wire

// ----- design/nearest_neighbour_tour_search_top.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbour_tour_search_top
// Repetitive nearest-neighbor tour search over a complete weighted graph.
// ----------------------------------------------------------------------------
// Each input item stores one symmetric edge weight and is taken while the block is idle.
// The item flagged last_edge starts the search: for every start node a greedy
// tour is built by scanning the weight memory one pair per cycle through its
// single read port. The best tour then leaves as n items, each read from a
// route bank and loaded into the output register once that is free; no input
// is taken from the last item until the final tour edge is in the output
// register. node_count is read at address 0; values below 2 act as 2 and
// above MAX_NODES as MAX_NODES.
`default_nettype none

module nearest_neighbour_tour_search_top #(
  parameter int unsigned MAX_NODES   = nnts_pkg::MAX_NODES_DEF,
  parameter int unsigned WEIGHT_BITS = nnts_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [nnts_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [nnts_pkg::PDATA_W-1:0]   pwdata,
  output logic [nnts_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [nnts_pkg::NODE_W-1:0]    node_a_i,
  input  wire logic [nnts_pkg::NODE_W-1:0]    node_b_i,
  input  wire logic [nnts_pkg::WEIGHT_W-1:0]  edge_weight_i,
  input  wire logic                           last_edge_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [nnts_pkg::NODE_W-1:0]         from_node_o,
  output logic [nnts_pkg::NODE_W-1:0]         to_node_o,
  output logic [nnts_pkg::WEIGHT_W-1:0]       step_weight_o,
  output logic [nnts_pkg::LEN_W-1:0]          tour_length_o,
  output logic                                last_in_tour_o
);

  localparam int unsigned IDX_W = $clog2(MAX_NODES);

  logic [nnts_pkg::CFG_W-1:0] node_count_q;
  logic                       reg_sel;
  nnts_pkg::cmd_t             cmd;
  logic                       out_free;
  logic [IDX_W-1:0]           start_idx, scan_idx, route_idx, emit_idx;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == nnts_pkg::REG_NODE_COUNT);
  assign prdata  = reg_sel ? nnts_pkg::PDATA_W'(node_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= nnts_pkg::NODE_COUNT_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      node_count_q <= pwdata[nnts_pkg::CFG_W-1:0];
    end
  end

  nnts_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_last_i    (last_edge_i),
    .in_ready_o   (in_ready_o),
    .node_count_i (node_count_q),
    .out_free_i   (out_free),
    .cmd_o        (cmd),
    .start_idx_o  (start_idx),
    .scan_idx_o   (scan_idx),
    .route_idx_o  (route_idx),
    .emit_idx_o   (emit_idx)
  );

  nnts_dp #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .start_idx_i    (start_idx),
    .scan_idx_i     (scan_idx),
    .route_idx_i    (route_idx),
    .emit_idx_i     (emit_idx),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .edge_weight_i  (edge_weight_i),
    .out_free_o     (out_free),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .from_node_o    (from_node_o),
    .to_node_o      (to_node_o),
    .step_weight_o  (step_weight_o),
    .tour_length_o  (tour_length_o),
    .last_in_tour_o (last_in_tour_o)
  );

endmodule

`default_nettype wire

// ----- design/nnts_ctrl.sv -----
// ----------------------------------------------------------------------------
// nnts_ctrl
// Sequencer: edge loading, per-start tour build, scan/pick loops, emission.
// ----------------------------------------------------------------------------
`default_nettype none

module nnts_ctrl #(
  parameter int unsigned MAX_NODES = nnts_pkg::MAX_NODES_DEF,
  localparam int unsigned IDX_W    = $clog2(MAX_NODES),
  localparam int unsigned CNT_W    = $clog2(MAX_NODES + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_last_i,
  output logic                            in_ready_o,
  input  wire logic [nnts_pkg::CFG_W-1:0] node_count_i,
  input  wire logic                       out_free_i,
  output nnts_pkg::cmd_t                  cmd_o,
  output logic [IDX_W-1:0]                start_idx_o,
  output logic [IDX_W-1:0]                scan_idx_o,
  output logic [IDX_W-1:0]                route_idx_o,
  output logic [IDX_W-1:0]                emit_idx_o
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_INIT     = 9'b000000010,
    ST_SCAN     = 9'b000000100,
    ST_DRAIN    = 9'b000001000,
    ST_PICK     = 9'b000010000,
    ST_CLOSE_RD = 9'b000100000,
    ST_CLOSE    = 9'b001000000,
    ST_EMIT_RD  = 9'b010000000,
    ST_EMIT_LD  = 9'b100000000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] s_q, s_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [CNT_W-1:0] e_q, e_d;
  logic [CNT_W-1:0] n_last;
  logic [CNT_W-1:0] n_clamp;
  int unsigned      cfg_v;

  assign n_last = n_q - CNT_W'(1);

  always_comb begin
    cfg_v = 32'(node_count_i);
    if (cfg_v < 2) begin
      n_clamp = CNT_W'(2);
    end else if (cfg_v > MAX_NODES) begin
      n_clamp = CNT_W'(MAX_NODES);
    end else begin
      n_clamp = CNT_W'(cfg_v);
    end
  end

  assign start_idx_o = s_q[IDX_W-1:0];
  assign scan_idx_o  = j_q[IDX_W-1:0];
  assign route_idx_o = k_q[IDX_W-1:0];
  assign emit_idx_o  = (e_q == n_q) ? '0 : e_q[IDX_W-1:0];

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    s_d        = s_q;
    k_d        = k_q;
    j_d        = j_q;
    e_d        = e_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.write_in = in_valid_i;
        if (in_valid_i && in_last_i) begin
          cmd_o.begin_search = 1'b1;
          n_d     = n_clamp;
          s_d     = '0;
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.init_tour = 1'b1;
        k_d     = CNT_W'(1);
        j_d     = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        j_d = j_q + CNT_W'(1);
        if (j_q == n_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_PICK;
      end
      ST_PICK: begin
        cmd_o.pick = 1'b1;
        j_d = '0;
        if (k_q == n_last) begin
          state_d = ST_CLOSE_RD;
        end else begin
          k_d     = k_q + CNT_W'(1);
          state_d = ST_SCAN;
        end
      end
      ST_CLOSE_RD: begin
        cmd_o.close_rd = 1'b1;
        state_d = ST_CLOSE;
      end
      ST_CLOSE: begin
        cmd_o.close = 1'b1;
        if (s_q == n_last) begin
          e_d     = CNT_W'(1);
          state_d = ST_EMIT_RD;
        end else begin
          s_d     = s_q + CNT_W'(1);
          state_d = ST_INIT;
        end
      end
      ST_EMIT_RD: begin
        cmd_o.emit_rd    = 1'b1;
        cmd_o.emit_first = (e_q == CNT_W'(1));
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (out_free_i) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.emit_last = (e_q == n_q);
          if (e_q == n_q) begin
            state_d = ST_IDLE;
          end else begin
            e_d     = e_q + CNT_W'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= CNT_W'(MAX_NODES);
      s_q     <= '0;
      k_q     <= '0;
      j_q     <= '0;
      e_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      s_q     <= s_d;
      k_q     <= k_d;
      j_q     <= j_d;
      e_q     <= e_d;
    end
  end

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> j_q < n_q)
    else $error("scan index beyond node count");

  a_last_start_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLOSE && s_q == n_last) |=> state_q == ST_EMIT_RD)
    else $error("search did not move to emission after last start");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_out && cmd_o.emit_last) |=> in_ready_o)
    else $error("block not ready after last tour edge");

endmodule

`default_nettype wire

// ----- design/nnts_dp.sv -----
// ----------------------------------------------------------------------------
// nnts_dp
// Datapath: weight memory, nearest-node compare, tour lengths, route banks,
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nnts_dp #(
  parameter int unsigned MAX_NODES   = nnts_pkg::MAX_NODES_DEF,
  parameter int unsigned WEIGHT_BITS = nnts_pkg::WEIGHT_BITS_DEF,
  localparam int unsigned IDX_W      = $clog2(MAX_NODES)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire nnts_pkg::cmd_t                cmd_i,
  input  wire logic [IDX_W-1:0]              start_idx_i,
  input  wire logic [IDX_W-1:0]              scan_idx_i,
  input  wire logic [IDX_W-1:0]              route_idx_i,
  input  wire logic [IDX_W-1:0]              emit_idx_i,
  input  wire logic [nnts_pkg::NODE_W-1:0]   node_a_i,
  input  wire logic [nnts_pkg::NODE_W-1:0]   node_b_i,
  input  wire logic [nnts_pkg::WEIGHT_W-1:0] edge_weight_i,
  output logic                               out_free_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [nnts_pkg::NODE_W-1:0]        from_node_o,
  output logic [nnts_pkg::NODE_W-1:0]        to_node_o,
  output logic [nnts_pkg::WEIGHT_W-1:0]      step_weight_o,
  output logic [nnts_pkg::LEN_W-1:0]         tour_length_o,
  output logic                               last_in_tour_o
);

  localparam int unsigned DEPTH  = MAX_NODES * MAX_NODES;
  localparam int unsigned ADDR_W = 2 * IDX_W;
  localparam int unsigned RT_W   = IDX_W + WEIGHT_BITS;
  localparam int unsigned LEN_W  = nnts_pkg::LEN_W;
  localparam int unsigned SUM_W  = ((LEN_W > WEIGHT_BITS) ? LEN_W : WEIGHT_BITS) + 1;

  // Weight store: upper triangle, address {lower index, higher index}
  logic [WEIGHT_BITS-1:0] wmem_q [DEPTH];
  logic [WEIGHT_BITS-1:0] w_rdata_q;
  logic [ADDR_W-1:0]      w_waddr, w_raddr;
  logic [IDX_W-1:0]       wa, wb, rx;
  logic                   w_we, w_re;

  // Route banks: entry k holds {node, weight of edge arriving at it};
  // entry 0 holds the start node and the closing edge weight.
  logic [RT_W-1:0]        route_q [2*MAX_NODES];
  logic [RT_W-1:0]        r_rdata_q;
  logic [RT_W-1:0]        r_wdata;
  logic [IDX_W:0]         r_waddr;
  logic                   r_we;

  logic [MAX_NODES-1:0]   visited_q;
  logic [IDX_W-1:0]       cur_q;
  logic [IDX_W-1:0]       j_d_q;
  logic                   cmp_vld_q;
  logic                   have_q;
  logic [WEIGHT_BITS-1:0] bestw_q;
  logic [IDX_W-1:0]       pick_q;
  logic [LEN_W-1:0]       cur_len_q;
  logic [LEN_W-1:0]       best_len_q;
  logic                   best_found_q;
  logic [IDX_W-1:0]       best_start_q;
  logic                   best_bank_q;
  logic [IDX_W-1:0]       prev_q;

  logic [WEIGHT_BITS-1:0] add_w;
  logic [SUM_W-1:0]       sum;
  logic [LEN_W-1:0]       sat_len;
  logic                   better;

  logic                   out_valid_q;
  logic [IDX_W-1:0]       out_from_q, out_to_q;
  logic [WEIGHT_BITS-1:0] out_w_q;
  logic [LEN_W-1:0]       out_len_q;
  logic                   out_last_q;

  // Edge load
  assign wa      = IDX_W'(node_a_i);
  assign wb      = IDX_W'(node_b_i);
  assign w_we    = cmd_i.write_in && (32'(node_a_i) < MAX_NODES)
                   && (32'(node_b_i) < MAX_NODES);
  assign w_waddr = (wa < wb) ? {wa, wb} : {wb, wa};

  // Weight read for scan or closing edge
  assign rx      = cmd_i.close_rd ? start_idx_i : scan_idx_i;
  assign w_raddr = (cur_q < rx) ? {cur_q, rx} : {rx, cur_q};
  assign w_re    = cmd_i.scan_rd || cmd_i.close_rd;

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      wmem_q[w_waddr] <= WEIGHT_BITS'(edge_weight_i);
    end
    if (w_re) begin
      w_rdata_q <= wmem_q[w_raddr];
    end
  end

  // Saturating length add
  assign add_w   = cmd_i.close ? w_rdata_q : bestw_q;
  assign sum     = SUM_W'(cur_len_q) + SUM_W'(add_w);
  assign sat_len = (sum > SUM_W'(nnts_pkg::LEN_MAX)) ? nnts_pkg::LEN_MAX : LEN_W'(sum);
  assign better  = !best_found_q || (sat_len < best_len_q);

  // Route write
  assign r_we    = cmd_i.pick || cmd_i.close;
  assign r_waddr = {~best_bank_q, (cmd_i.pick ? route_idx_i : IDX_W'(0))};
  assign r_wdata = cmd_i.pick ? {pick_q, bestw_q} : {start_idx_i, w_rdata_q};

  always_ff @(posedge clk_i) begin
    if (r_we) begin
      route_q[r_waddr] <= r_wdata;
    end
    if (cmd_i.emit_rd) begin
      r_rdata_q <= route_q[{best_bank_q, emit_idx_i}];
    end
  end

  // Search control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q    <= '0;
      cmp_vld_q    <= 1'b0;
      have_q       <= 1'b0;
      cur_len_q    <= '0;
      best_len_q   <= '0;
      best_found_q <= 1'b0;
      best_bank_q  <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan_rd;
      if (cmd_i.begin_search) begin
        best_found_q <= 1'b0;
      end
      if (cmd_i.init_tour) begin
        visited_q <= MAX_NODES'(1) << start_idx_i;
        cur_len_q <= '0;
        have_q    <= 1'b0;
      end else if (cmd_i.pick) begin
        visited_q[pick_q] <= 1'b1;
        cur_len_q <= sat_len;
        have_q    <= 1'b0;
      end else if (cmp_vld_q && !visited_q[j_d_q] && (!have_q || w_rdata_q < bestw_q)) begin
        have_q <= 1'b1;
      end
      if (cmd_i.close && better) begin
        best_found_q <= 1'b1;
        best_len_q   <= sat_len;
        best_bank_q  <= ~best_bank_q;
      end
    end
  end

  // Search payload
  always_ff @(posedge clk_i) begin
    j_d_q <= scan_idx_i;
    if (cmd_i.init_tour) begin
      cur_q <= start_idx_i;
    end else if (cmd_i.pick) begin
      cur_q <= pick_q;
    end
    if (cmp_vld_q && !visited_q[j_d_q] && (!have_q || w_rdata_q < bestw_q)) begin
      bestw_q <= w_rdata_q;
      pick_q  <= j_d_q;
    end
    if (cmd_i.close && better) begin
      best_start_q <= start_idx_i;
    end
    if (cmd_i.emit_first) begin
      prev_q <= best_start_q;
    end else if (cmd_i.load_out) begin
      prev_q <= r_rdata_q[RT_W-1 -: IDX_W];
    end
  end

  // Output register
  assign out_free_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_from_q <= prev_q;
      out_to_q   <= r_rdata_q[RT_W-1 -: IDX_W];
      out_w_q    <= r_rdata_q[WEIGHT_BITS-1:0];
      out_len_q  <= best_len_q;
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign from_node_o    = nnts_pkg::NODE_W'(out_from_q);
  assign to_node_o      = nnts_pkg::NODE_W'(out_to_q);
  assign step_weight_o  = nnts_pkg::WEIGHT_W'(out_w_q);
  assign tour_length_o  = out_len_q;
  assign last_in_tour_o = out_last_q;

  a_pick_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pick |-> have_q)
    else $error("pick without an unvisited candidate");

  a_pick_unvisited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pick |-> !visited_q[pick_q])
    else $error("picked node already visited");

endmodule

`default_nettype wire

// ----- dv/tb_nearest_neighbour_tour_search_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_neighbour_tour_search_top
// Self-checking testbench for the nearest-neighbor tour search block.
// ----------------------------------------------------------------------------
// Edge weights stream in over a valid/ready channel, and node_count is set
// over APB while the block is idle. A behavioral tour planner mirrors the
// weight memory and predicts every tour edge of the best tour. A directed
// table covers extremes, ties, diagonal and out-of-range writes and clamped
// node counts. Random phases then load every missing pair of the active node
// set in random order with noise edges mixed in, and close with a search.
// ----------------------------------------------------------------------------

module tb_nearest_neighbour_tour_search_top;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int IDLE_SETTLE  = 8;
  localparam int TAIL_CYCLES  = 50;
  localparam int MAX_REPORTS  = 10;
  localparam int RAND_ITEMS   = 120;
  localparam int RAND_TOURS   = 48;
  localparam int NODES        = nnts_pkg::MAX_NODES_DEF;

  typedef struct packed {
    logic [nnts_pkg::NODE_W-1:0]   a;
    logic [nnts_pkg::NODE_W-1:0]   b;
    logic [nnts_pkg::WEIGHT_W-1:0] w;
    logic                          last;
  } edge_item_t;

  typedef struct packed {
    logic [nnts_pkg::NODE_W-1:0]   from_node;
    logic [nnts_pkg::NODE_W-1:0]   to_node;
    logic [nnts_pkg::WEIGHT_W-1:0] step_weight;
    logic [nnts_pkg::LEN_W-1:0]    tour_length;
    logic                          last_in_tour;
  } tour_edge_t;

  // cfg rows write node_count; typed rows carry a two-node tour length
  typedef struct packed {
    logic                          cfg;
    logic [nnts_pkg::CFG_W-1:0]    count;
    logic [nnts_pkg::NODE_W-1:0]   a;
    logic [nnts_pkg::NODE_W-1:0]   b;
    logic [nnts_pkg::WEIGHT_W-1:0] w;
    logic                          last;
    logic                          typed;
    logic [nnts_pkg::LEN_W-1:0]    len;
  } dir_row_t;

  localparam dir_row_t DIRECTED [23] = '{
    '{1'b1, 5'd0,  4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 20'h00000},
    '{1'b0, 5'd0,  4'd0,  4'd1,  16'hFFFF, 1'b1, 1'b1, 20'h1FFFE},
    '{1'b0, 5'd0,  4'd1,  4'd0,  16'h0000, 1'b1, 1'b1, 20'h00000},
    '{1'b0, 5'd0,  4'd0,  4'd0,  16'h04D2, 1'b0, 1'b0, 20'h00000},
    '{1'b0, 5'd0,  4'd15, 4'd15, 16'hFFFF, 1'b0, 1'b0, 20'h00000},
    '{1'b0, 5'd0,  4'd15, 4'd14, 16'hAAAA, 1'b0, 1'b0, 20'h00000},
    '{1'b0, 5'd0,  4'd1,  4'd0,  16'h0007, 1'b1, 1'b1, 20'h0000E},
    '{1'b1, 5'd1,  4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 20'h00000},
    '{1'b0, 5'd0,  4'd0,  4'd1,  16'h0005, 1'b1, 1'b1, 20'h0000A},
    '{1'b1, 5'd2,  4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 20'h00000},
    '{1'b0, 5'd0,  4'd2,  4'd3,  16'h5555, 1'b0, 1'b0, 20'h00000},
    '{1'b0, 5'd0,  4'd0,  4'd1,  16'h8000, 1'b1, 1'b1, 20'h10000},
    '{1'b1, 5'd3,  4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 20'h00000},
    '{1'b0, 5'd0,  4'd0,  4'd2,  16'h0003, 1'b0, 1'b0, 20'h00000},
    '{1'b0, 5'd0,  4'd1,  4'd2,  16'h0003, 1'b0, 1'b0, 20'h00000},
    '{1'b0, 5'd0,  4'd0,  4'd1,  16'h0003, 1'b1, 1'b0, 20'h00000},
    '{1'b1, 5'd4,  4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 20'h00000},
    '{1'b0, 5'd0,  4'd0,  4'd3,  16'h0001, 1'b0, 1'b0, 20'h00000},
    '{1'b0, 5'd0,  4'd1,  4'd3,  16'h0064, 1'b0, 1'b0, 20'h00000},
    '{1'b0, 5'd0,  4'd2,  4'd3,  16'h0002, 1'b0, 1'b0, 20'h00000},
    '{1'b0, 5'd0,  4'd0,  4'd1,  16'h0001, 1'b0, 1'b0, 20'h00000},
    '{1'b0, 5'd0,  4'd0,  4'd2,  16'h0032, 1'b0, 1'b0, 20'h00000},
    '{1'b0, 5'd0,  4'd1,  4'd2,  16'h0001, 1'b1, 1'b0, 20'h00000}
  };

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          psel           = 1'b0;
  logic                          penable        = 1'b0;
  logic                          pwrite         = 1'b0;
  logic [nnts_pkg::PADDR_W-1:0]  paddr          = '0;
  logic [nnts_pkg::PDATA_W-1:0]  pwdata         = '0;
  logic [nnts_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;
  logic                          in_valid_i     = 1'b0;
  logic                          in_ready_o;
  logic [nnts_pkg::NODE_W-1:0]   node_a_i       = '0;
  logic [nnts_pkg::NODE_W-1:0]   node_b_i       = '0;
  logic [nnts_pkg::WEIGHT_W-1:0] edge_weight_i  = '0;
  logic                          last_edge_i    = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i    = 1'b0;
  logic [nnts_pkg::NODE_W-1:0]   from_node_o;
  logic [nnts_pkg::NODE_W-1:0]   to_node_o;
  logic [nnts_pkg::WEIGHT_W-1:0] step_weight_o;
  logic [nnts_pkg::LEN_W-1:0]    tour_length_o;
  logic                          last_in_tour_o;

  nearest_neighbour_tour_search_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .edge_weight_i  (edge_weight_i),
    .last_edge_i    (last_edge_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .from_node_o    (from_node_o),
    .to_node_o      (to_node_o),
    .step_weight_o  (step_weight_o),
    .tour_length_o  (tour_length_o),
    .last_in_tour_o (last_in_tour_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  logic [nnts_pkg::WEIGHT_W-1:0] edge_weights [NODES][NODES];
  bit                            pair_loaded  [NODES][NODES];
  logic [nnts_pkg::CFG_W-1:0]    node_count_reg = nnts_pkg::NODE_COUNT_RST;
  tour_edge_t                    tour_edges_q [$];

  int unsigned cycle_count  = 0;
  int          n_fail       = 0;
  int          tx_gap       = 0;
  bit          tx_gaps_on   = 1'b1;
  bit          rx_gaps_on   = 1'b1;
  bit          rx_long_hold = 1'b0;

  function automatic int tour_nodes(input logic [nnts_pkg::CFG_W-1:0] raw);
    if (raw < 2) return 2;
    if (raw > NODES) return NODES;
    return int'(raw);
  endfunction

  function automatic logic [nnts_pkg::LEN_W-1:0] add_len(
      input logic [nnts_pkg::LEN_W-1:0] acc,
      input logic [nnts_pkg::WEIGHT_W-1:0] w);
    logic [nnts_pkg::LEN_W:0] sum;
    sum = {1'b0, acc} + (nnts_pkg::LEN_W+1)'(w);
    return (sum > {1'b0, nnts_pkg::LEN_MAX}) ? nnts_pkg::LEN_MAX
                                             : sum[nnts_pkg::LEN_W-1:0];
  endfunction

  function automatic logic [nnts_pkg::WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return nnts_pkg::WEIGHT_W'($urandom_range(0, 3));
      default: return nnts_pkg::WEIGHT_W'($urandom);
    endcase
  endfunction

  // Greedy tour from every start; shortest kept, earliest start on ties.
  task automatic predict_best_tour();
    int n, s, k, j, cur, pick;
    logic [nnts_pkg::NODE_W-1:0]   route      [NODES];
    logic [nnts_pkg::NODE_W-1:0]   best_route [NODES];
    logic [nnts_pkg::LEN_W-1:0]    len, best_len;
    logic [nnts_pkg::WEIGHT_W-1:0] near_w;
    logic [NODES-1:0]              seen;
    bit                            have, found;
    tour_edge_t                    e;
    n = tour_nodes(node_count_reg);
    found = 1'b0;
    best_len = '0;
    for (s = 0; s < n; s++) begin
      seen = '0;
      seen[s] = 1'b1;
      cur = s;
      len = '0;
      route[0] = nnts_pkg::NODE_W'(s);
      for (k = 1; k < n; k++) begin
        have = 1'b0;
        pick = 0;
        near_w = '0;
        for (j = 0; j < n; j++) begin
          if (!seen[j] && (!have || edge_weights[cur][j] < near_w)) begin
            have = 1'b1;
            near_w = edge_weights[cur][j];
            pick = j;
          end
        end
        seen[pick] = 1'b1;
        route[k] = nnts_pkg::NODE_W'(pick);
        len = add_len(len, near_w);
        cur = pick;
      end
      len = add_len(len, edge_weights[cur][s]);
      if (!found || len < best_len) begin
        found = 1'b1;
        best_len = len;
        best_route = route;
      end
    end
    for (k = 0; k < n; k++) begin
      e.from_node    = best_route[k];
      e.to_node      = best_route[(k + 1) % n];
      e.step_weight  = edge_weights[e.from_node][e.to_node];
      e.tour_length  = best_len;
      e.last_in_tour = (k == n - 1);
      tour_edges_q.push_back(e);
    end
  endtask

  // Returns in the cycle the item is taken; valid stays up only if the
  // next item follows with no gap.
  task automatic offer_edge(input edge_item_t it, input bit skip_search);
    repeat (tx_gap) @(posedge clk_i);
    in_valid_i    <= 1'b1;
    node_a_i      <= it.a;
    node_b_i      <= it.b;
    edge_weight_i <= it.w;
    last_edge_i   <= it.last;
    do @(posedge clk_i); while (!in_ready_o);
    tx_gap = tx_gaps_on ? $urandom_range(0, 11) : 0;
    if (tx_gap != 0) in_valid_i <= 1'b0;
    edge_weights[it.a][it.b] = it.w;
    edge_weights[it.b][it.a] = it.w;
    pair_loaded[it.a][it.b]  = 1'b1;
    pair_loaded[it.b][it.a]  = 1'b1;
    if (it.last && !skip_search) predict_best_tour();
  endtask

  task automatic stop_offering();
    if (tx_gap == 0) in_valid_i <= 1'b0;
  endtask

  task automatic write_node_count(input logic [nnts_pkg::CFG_W-1:0] value);
    stop_offering();
    while (tour_edges_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_SETTLE) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {nnts_pkg::REG_NODE_COUNT, 2'b00};
    pwdata  <= nnts_pkg::PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    node_count_reg = value;
  endtask

  initial begin : cycle_guard
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : tour_sink
    int         gap;
    tour_edge_t got, want;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = rx_gaps_on ? $urandom_range(0, 11) : 0;
      if (rx_long_hold) begin
        gap = 300 + $urandom_range(0, 200);
        rx_long_hold = 1'b0;
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got = '{from_node_o, to_node_o, step_weight_o, tour_length_o, last_in_tour_o};
      if (tour_edges_q.size() == 0) begin
        if (n_fail < MAX_REPORTS)
          $display("unexpected tour edge %0d->%0d w=%0d len=%0d last=%0b",
                   got.from_node, got.to_node, got.step_weight, got.tour_length,
                   got.last_in_tour);
        n_fail++;
      end else begin
        want = tour_edges_q.pop_front();
        if (got !== want) begin
          if (n_fail < MAX_REPORTS)
            $display("tour edge mismatch: exp %0d->%0d w=%0d len=%0d last=%0b, %s",
                     want.from_node, want.to_node, want.step_weight,
                     want.tour_length, want.last_in_tour,
                     $sformatf("got %0d->%0d w=%0d len=%0d last=%0b",
                               got.from_node, got.to_node, got.step_weight,
                               got.tour_length, got.last_in_tour));
          n_fail++;
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t   r;
    edge_item_t it, tmp;
    edge_item_t batch [$];
    tour_edge_t e;
    int         phase, n, k, extras, rand_items, rand_tours;
    logic [nnts_pkg::CFG_W-1:0] raw;
    bit         keep, full_loaded;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      r = DIRECTED[i];
      if (r.cfg) begin
        write_node_count(r.count);
      end else begin
        offer_edge(edge_item_t'{r.a, r.b, r.w, r.last}, r.typed);
        if (r.typed) begin
          e = '{nnts_pkg::NODE_W'(0), nnts_pkg::NODE_W'(1), r.w, r.len, 1'b0};
          tour_edges_q.push_back(e);
          e = '{nnts_pkg::NODE_W'(1), nnts_pkg::NODE_W'(0), r.w, r.len, 1'b1};
          tour_edges_q.push_back(e);
        end
      end
    end

    phase = 0;
    rand_items = 0;
    rand_tours = 0;
    full_loaded = 1'b0;
    while (!full_loaded || rand_items < RAND_ITEMS || rand_tours < RAND_TOURS) begin
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      // phase 2 keeps the setting so its items pile up behind a stalled sink
      keep = (phase == 2) || (phase > 5 && $urandom_range(0, 2) == 0);
      case (phase)
        3: raw = nnts_pkg::CFG_W'(16);
        4: raw = nnts_pkg::CFG_W'(31);
        5: raw = nnts_pkg::CFG_W'(17);
        default: begin
          if (!full_loaded) begin
            k = $urandom_range(0, 9);
            raw = (k < 2) ? nnts_pkg::CFG_W'(k)
                          : nnts_pkg::CFG_W'($urandom_range(2, 6));
          end else begin
            raw = nnts_pkg::CFG_W'($urandom_range(0, 31));
          end
        end
      endcase
      if (!keep) write_node_count(raw);
      if (phase == 1) rx_long_hold = 1'b1;

      n = tour_nodes(node_count_reg);
      batch.delete();
      for (int i = 0; i < n; i++)
        for (int j = i + 1; j < n; j++)
          if (!pair_loaded[i][j])
            batch.push_back(edge_item_t'{nnts_pkg::NODE_W'(i), nnts_pkg::NODE_W'(j),
                                         rand_weight(), 1'b0});
      extras = $urandom_range(0, 4);
      repeat (extras)
        batch.push_back(edge_item_t'{nnts_pkg::NODE_W'($urandom_range(0, 15)),
                                     nnts_pkg::NODE_W'($urandom_range(0, 15)),
                                     rand_weight(), 1'b0});
      for (int i = batch.size() - 1; i > 0; i--) begin
        k = $urandom_range(0, i);
        tmp = batch[i];
        batch[i] = batch[k];
        batch[k] = tmp;
      end
      batch.push_back(edge_item_t'{nnts_pkg::NODE_W'($urandom_range(0, 15)),
                                   nnts_pkg::NODE_W'($urandom_range(0, 15)),
                                   rand_weight(), 1'b1});
      foreach (batch[i]) begin
        it = batch[i];
        offer_edge(it, 1'b0);
        rand_items++;
      end
      rand_tours += n;
      if (n == NODES) full_loaded = 1'b1;
      phase++;
    end

    stop_offering();
    while (tour_edges_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_fail == 0 && tour_edges_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/nnts_pkg.sv
design/nnts_ctrl.sv
design/nnts_dp.sv
design/nearest_neighbour_tour_search_top.sv
dv/tb_nearest_neighbour_tour_search_top.sv
